// ----- rtl/can_bts_pkg.sv -----
package can_bts_pkg;

   localparam int MAX_SEG_ONE  = 15;
   localparam int MAX_SEG_TWO  = 7;
   localparam int MAX_PRESCALE = 64;

   localparam int OSC_W   = 26;
   localparam int RATE_W  = 20;
   localparam int SP_W    = 7;
   localparam int DIV_W   = OSC_W - 1;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int TT_W    = 6;
   localparam int SEG_W   = 5;
   localparam int PRE_W   = 7;
   localparam int ERR_W   = DIV_W;
   localparam int TEN_W   = ERR_W + 4;

   localparam int T_FIRST = 4;
   localparam int T_LAST  = (MAX_SEG_ONE + MAX_SEG_TWO + 2) * 2 + 1;
   localparam int PERCENT = 100;
   localparam int ERR_RATIO = 10;

   localparam logic [OSC_W-1:0] OSC_RESET = OSC_W'(16000000);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      CSR_OSCILLATOR = 1'b0,
      CSR_UNUSED     = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUOT_START,
      ST_QUOT_WAIT,
      ST_GOT_START,
      ST_GOT_WAIT,
      ST_NEXT,
      ST_SPLIT_START,
      ST_SPLIT_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/can_bts_div.sv -----
module can_bts_div (
   input  logic                     clock,
   input  logic                     reset,
   input  can_bts_pkg::div_req_type div_req,
   output can_bts_pkg::div_rsp_type div_rsp
);
   import can_bts_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     dvd_ff;
   logic [DIV_W-1:0]     divisor_ff;
   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       diff;
   logic                 fits;

   // One quotient bit per cycle; the dividend register fills with quotient bits.
   always_comb begin
      trial = {rem_ff, dvd_ff[DIV_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = trial >= {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= '0;
         dvd_ff     <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         dvd_ff <= {dvd_ff[DIV_W-2:0], fits};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

// ----- rtl/can_bit_timing_search_unit.sv -----
// A request with a zero bit rate goes straight to the done state; any other request is searched
// with the bit-serial divider: 46 candidates of one or two divisions each (each division has a
// start state, 25 quotient bits and a done strobe), plus one more division for the segment
// split unless the search failed.
// One request is handled at a time; the next is taken once the result is registered.
// Reset is synchronous and active high; it restores the oscillator setting to 16 MHz.
module can_bit_timing_search_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [can_bts_pkg::RATE_W-1:0]         req_bit_rate,
   input  logic [1:0]                             req_jump_width,
   input  logic [can_bts_pkg::SP_W-1:0]           req_sample_point_percent,
   input  logic                                   req_triple_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [7:0]                             rsp_timing_byte0,
   output logic [7:0]                             rsp_timing_byte1,
   output logic                                   rsp_status,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [can_bts_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [can_bts_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [can_bts_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                   csr_pready
);
   import can_bts_pkg::*;

   state_type state_ff, state_in;

   logic [OSC_W-1:0]  osc_ff;
   logic [RATE_W-1:0] rate_ff;
   logic [1:0]        sjw_ff;
   logic [SP_W-1:0]   sp_ff;
   logic              tri_ff;
   logic [TT_W-1:0]   t_ff;
   logic [DIV_W-1:0]  nr_ff;
   logic [PRE_W-1:0]  p_ff;
   logic              found_ff;
   logic [ERR_W-1:0]  best_err_ff;
   logic [SEG_W-1:0]  best_t_ff;
   logic [5:0]        best_p_ff;
   logic [SEG_W-1:0]  q100_ff;
   logic              rsp_valid_ff;
   logic [7:0]        byte0_ff;
   logic [7:0]        byte1_ff;
   logic              status_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [DIV_W-1:0]  clk_half;
   logic [SEG_W-1:0]  n;
   logic [DIV_W-1:0]  p_full;
   logic              p_ok;
   logic [DIV_W-1:0]  rate_ext;
   logic [ERR_W-1:0]  err;
   logic              better;
   logic [TEN_W-1:0]  ten_err;
   logic              fail;
   logic              last;
   logic [11:0]       pn;
   logic [11:0]       spt;
   logic              csr_write;

   logic signed [6:0] tt, qq, s2a, seg2a, s1a, seg1, seg2, s2b;
   logic [7:0]        byte0, byte1;

   logic              do_accept, do_take_p, do_take_best, do_step, do_take_q, do_out;

   can_bts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Configuration register.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_index_type'(csr_paddr[2]) == CSR_OSCILLATOR) ?
                       CSR_DATA_W'(osc_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         osc_ff <= OSC_RESET;
      end else if (csr_write && csr_index_type'(csr_paddr[2]) == CSR_OSCILLATOR) begin
         osc_ff <= csr_pwdata[OSC_W-1:0];
      end
   end

   // Candidate arithmetic.
   always_comb begin
      clk_half = osc_ff[OSC_W-1:1];
      n        = t_ff[TT_W-1:1] + SEG_W'(1);
      p_full   = div_rsp.quotient + DIV_W'(t_ff[0]);
      p_ok     = (p_full != '0) && (p_full <= DIV_W'(MAX_PRESCALE));
      rate_ext = DIV_W'(rate_ff);
      err      = (rate_ext >= div_rsp.quotient) ? rate_ext - div_rsp.quotient
                                                : div_rsp.quotient - rate_ext;
      better   = !found_ff || (err <= best_err_ff);
      ten_err  = TEN_W'({best_err_ff, 3'b000}) + TEN_W'({best_err_ff, 1'b0});
      // floor(rate / err) < 10 is the same as rate < 10 * err.
      fail     = !found_ff || ((best_err_ff != '0) && (TEN_W'(rate_ff) < ten_err));
      last     = t_ff == TT_W'(T_LAST);
      pn       = 12'(p_ff) * 12'(n);
      spt      = 12'(sp_ff) * 12'(best_t_ff + SEG_W'(1));
   end

   // Segment split and byte packing.
   always_comb begin
      tt  = {2'b00, best_t_ff};
      qq  = {2'b00, q100_ff};
      s2a = tt - qq;
      if (s2a < 7'sd0) begin
         seg2a = 7'sd0;
      end else if (s2a > 7'(MAX_SEG_TWO)) begin
         seg2a = 7'(MAX_SEG_TWO);
      end else begin
         seg2a = s2a;
      end
      s1a = tt - seg2a - 7'sd2;
      s2b = tt - 7'(MAX_SEG_ONE) - 7'sd2;
      seg1 = (s1a < 7'sd0) ? 7'sd0 : s1a;
      seg2 = seg2a;
      if (seg1 > 7'(MAX_SEG_ONE)) begin
         seg1 = 7'(MAX_SEG_ONE);
         if (s2b < 7'sd0) begin
            seg2 = 7'sd0;
         end else if (s2b > 7'(MAX_SEG_TWO)) begin
            seg2 = 7'(MAX_SEG_TWO);
         end else begin
            seg2 = s2b;
         end
      end
      byte0 = fail ? 8'h00 : {sjw_ff, best_p_ff};
      byte1 = fail ? 8'h00 : {tri_ff, seg2[2:0], seg1[3:0]};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_bit_rate == '0) ? ST_DONE : ST_QUOT_START;
            end
         end
         ST_QUOT_START: state_in = ST_QUOT_WAIT;
         ST_QUOT_WAIT: begin
            if (div_rsp.done) begin
               state_in = p_ok ? ST_GOT_START : ST_NEXT;
            end
         end
         ST_GOT_START: state_in = ST_GOT_WAIT;
         ST_GOT_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (!last) begin
               state_in = ST_QUOT_START;
            end else begin
               state_in = fail ? ST_DONE : ST_SPLIT_START;
            end
         end
         ST_SPLIT_START: state_in = ST_SPLIT_WAIT;
         ST_SPLIT_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = clk_half;
      div_req.divisor  = nr_ff;
      do_take_p        = 1'b0;
      do_take_best     = 1'b0;
      do_step          = 1'b0;
      do_take_q        = 1'b0;
      do_out           = 1'b0;
      unique case (state_ff)
         ST_IDLE:        req_ready = 1'b1;
         ST_QUOT_START:  div_req.start = 1'b1;
         ST_QUOT_WAIT:   do_take_p = div_rsp.done && p_ok;
         ST_GOT_START: begin
            div_req.start   = 1'b1;
            div_req.divisor = DIV_W'(pn);
         end
         ST_GOT_WAIT:    do_take_best = div_rsp.done && better;
         ST_NEXT:        do_step = !last;
         ST_SPLIT_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(spt);
            div_req.divisor  = DIV_W'(PERCENT);
         end
         ST_SPLIT_WAIT:  do_take_q = div_rsp.done;
         ST_DONE:        do_out = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   assign do_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_accept) begin
         rate_ff  <= req_bit_rate;
         sjw_ff   <= req_jump_width;
         sp_ff    <= req_sample_point_percent;
         tri_ff   <= req_triple_sample;
         t_ff     <= TT_W'(T_FIRST);
         nr_ff    <= DIV_W'({req_bit_rate, 1'b0}) + DIV_W'(req_bit_rate);
         found_ff <= 1'b0;
      end
      if (do_take_p) begin
         p_ff <= p_full[PRE_W-1:0];
      end
      if (do_take_best) begin
         found_ff    <= 1'b1;
         best_err_ff <= err;
         best_t_ff   <= t_ff[TT_W-1:1];
         best_p_ff   <= 6'(p_ff - PRE_W'(1));
      end
      if (do_step) begin
         t_ff <= t_ff + TT_W'(1);
         // Quanta per bit grow by one when the doubled length goes from odd to even.
         if (t_ff[0]) begin
            nr_ff <= nr_ff + rate_ext;
         end
      end
      if (do_take_q) begin
         q100_ff <= div_rsp.quotient[SEG_W-1:0];
      end
      if (do_out) begin
         byte0_ff  <= byte0;
         byte1_ff  <= byte1;
         status_ff <= fail;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_timing_byte0 = byte0_ff;
   assign rsp_timing_byte1 = byte1_ff;
   assign rsp_status       = status_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_QUOT_WAIT || state_ff == ST_GOT_WAIT ||
                        state_ff == ST_SPLIT_WAIT))
      else $error("divider finished outside a wait state");

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QUOT_START |-> (t_ff >= TT_W'(T_FIRST) && t_ff <= TT_W'(T_LAST)))
      else $error("candidate length out of range");

   a_nr_track: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QUOT_START |-> nr_ff == DIV_W'(rate_ff) * DIV_W'(n))
      else $error("rate product does not match quanta count");

   a_best_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT_START) |-> (found_ff && best_t_ff >= SEG_W'(2)))
      else $error("segment split started without a valid candidate");

endmodule
